// File: hdl/ucs_pkg.sv
package ucs_pkg;

	// Byte position width: offsets run from zero to the maximum length
	localparam int MAX_URL_LEN = 4096;
	localparam int POS_W = 13;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_URL_LEN);

	localparam int NUM_COMP = 7;

	// Separator characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		COMP_SCHEME = 3'd0,
		COMP_USER   = 3'd1,
		COMP_HOST   = 3'd2,
		COMP_PORT   = 3'd3,
		COMP_PATH   = 3'd4,
		COMP_QUERY  = 3'd5,
		COMP_FRAG   = 3'd6
	} comp_t;

	localparam comp_t COMP_LAST = COMP_FRAG;

	typedef struct packed {
		logic             present;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] len;
	} rec_t;

	// One finished URL: all component records and the overflow mark
	typedef struct packed {
		rec_t [NUM_COMP-1:0] recs;
		logic                too_long;
	} batch_t;

	// Build a record spanning [s, e), empty when the end lies before the start
	function automatic rec_t mk_rec(input logic [POS_W-1:0] s, input logic [POS_W-1:0] e);
		rec_t r;
		r.present = 1'b1;
		r.start   = s;
		r.len     = (e >= s) ? (e - s) : '0;
		return r;
	endfunction

endpackage

// File: hdl/ucs_parser.sv
module ucs_parser import ucs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  logic [7:0]   url_byte,
	input  logic         final_byte,
	input  logic         emit_busy,
	output logic         batch_load,
	output batch_t       batch
);

	typedef enum logic [3:0] {
		PH_SKIP, PH_SCHEME, PH_SLASH1, PH_SLASH2, PH_HOST,
		PH_PORT, PH_PATH, PH_QUERY, PH_FRAG, PH_STOP
	} phase_t;

	logic                v_s1;
	logic [7:0]          byte_s1;
	logic                fin_s1;
	logic                adv;

	phase_t              ph_q, ph_d;
	logic [POS_W-1:0]    bpos_q;
	logic [POS_W-1:0]    seg_q, seg_d;
	logic                at_q, at_d;
	logic                ovf_q, ovf_d;
	rec_t [NUM_COMP-1:0] rec_q, rec_d, rec_f;

	logic [POS_W-1:0]    pos, nxt;
	logic                asg_en;
	comp_t               asg_c;
	logic [POS_W-1:0]    asg_s;
	logic                fin_en;
	comp_t               fin_c;

	// Hold the registered item while a final byte waits for the emitter
	assign adv        = ~fin_s1 | ~emit_busy;
	assign byte_stall = v_s1 & ~adv;
	assign batch_load = v_s1 & fin_s1 & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (~v_s1 | adv) begin
			v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((~v_s1 | adv) & byte_valid) begin
			byte_s1 <= url_byte;
			fin_s1  <= final_byte;
		end
	end

	// Advance the parse by one byte
	always_comb begin
		ovf_d  = ovf_q | (bpos_q >= POS_MAX);
		pos    = (bpos_q >= POS_MAX) ? POS_MAX : bpos_q;
		nxt    = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;
		ph_d   = ph_q;
		seg_d  = seg_q;
		at_d   = at_q;
		asg_en = 1'b0;
		asg_c  = COMP_SCHEME;
		asg_s  = seg_q;

		unique case (ph_q) inside
			PH_SKIP: begin
				if (byte_s1 != CH_SPACE) begin
					seg_d = pos;
					if (byte_s1 == CH_SLASH) begin
						ph_d = PH_PATH;
					end else if (byte_s1 == CH_COLON) begin
						asg_en = 1'b1;
						asg_s  = pos;
						ph_d   = PH_SLASH1;
					end else begin
						ph_d = PH_SCHEME;
					end
				end
			end
			PH_SCHEME: begin
				if (byte_s1 == CH_COLON) begin
					asg_en = 1'b1;
					ph_d   = PH_SLASH1;
				end
			end
			PH_SLASH1: begin
				ph_d = (byte_s1 == CH_SLASH) ? PH_SLASH2 : PH_STOP;
			end
			PH_SLASH2: begin
				if (byte_s1 == CH_SLASH) begin
					ph_d  = PH_HOST;
					seg_d = nxt;
					at_d  = 1'b0;
				end else begin
					ph_d = PH_STOP;
				end
			end
			PH_HOST: begin
				if (byte_s1 == CH_AT && !at_q) begin
					asg_en = 1'b1;
					asg_c  = COMP_USER;
					seg_d  = nxt;
					at_d   = 1'b1;
				end else if (byte_s1 == CH_COLON) begin
					asg_en = 1'b1;
					asg_c  = COMP_HOST;
					seg_d  = nxt;
					ph_d   = PH_PORT;
				end else if (byte_s1 == CH_SLASH) begin
					asg_en = 1'b1;
					asg_c  = COMP_HOST;
					seg_d  = pos;
					ph_d   = PH_PATH;
				end else if (byte_s1 == CH_QUEST) begin
					asg_en = 1'b1;
					asg_c  = COMP_HOST;
					seg_d  = nxt;
					ph_d   = PH_QUERY;
				end
			end
			PH_PORT: begin
				if (byte_s1 == CH_SLASH) begin
					asg_en = 1'b1;
					asg_c  = COMP_PORT;
					seg_d  = pos;
					ph_d   = PH_PATH;
				end else if (byte_s1 == CH_QUEST) begin
					asg_en = 1'b1;
					asg_c  = COMP_PORT;
					seg_d  = nxt;
					ph_d   = PH_QUERY;
				end
			end
			PH_PATH: begin
				if (byte_s1 == CH_QUEST) begin
					asg_en = 1'b1;
					asg_c  = COMP_PATH;
					seg_d  = nxt;
					ph_d   = PH_QUERY;
				end
			end
			PH_QUERY: begin
				if (byte_s1 == CH_HASH) begin
					asg_en = 1'b1;
					asg_c  = COMP_QUERY;
					seg_d  = nxt;
					ph_d   = PH_FRAG;
				end
			end
			PH_FRAG, PH_STOP: begin
			end
			default: begin
				ph_d = PH_STOP;
			end
		endcase

		rec_d = rec_q;
		if (asg_en) begin
			rec_d[asg_c] = mk_rec(asg_s, pos);
		end

		// Close the open component on the last byte
		fin_en = 1'b1;
		fin_c  = COMP_HOST;
		case (ph_d)
			PH_HOST:  fin_c = COMP_HOST;
			PH_PORT:  fin_c = COMP_PORT;
			PH_PATH:  fin_c = COMP_PATH;
			PH_QUERY: fin_c = COMP_QUERY;
			PH_FRAG:  fin_c = COMP_FRAG;
			default:  fin_en = 1'b0;
		endcase
		rec_f = rec_d;
		if (fin_en) begin
			rec_f[fin_c] = mk_rec(seg_d, nxt);
		end
	end

	assign batch.recs     = rec_f;
	assign batch.too_long = ovf_d;

	// Update the parse state; clear it once the URL is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SKIP;
			bpos_q <= '0;
			seg_q  <= '0;
			at_q   <= 1'b0;
			ovf_q  <= 1'b0;
			rec_q  <= '0;
		end else if (v_s1 & adv) begin
			if (fin_s1) begin
				ph_q   <= PH_SKIP;
				bpos_q <= '0;
				seg_q  <= '0;
				at_q   <= 1'b0;
				ovf_q  <= 1'b0;
				rec_q  <= '0;
			end else begin
				ph_q   <= ph_d;
				bpos_q <= nxt;
				seg_q  <= seg_d;
				at_q   <= at_d;
				ovf_q  <= ovf_d;
				rec_q  <= rec_d;
			end
		end
	end

endmodule

// File: hdl/ucs_emitter.sv
module ucs_emitter import ucs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             batch_load,
	input  batch_t           batch,
	output logic             emit_busy,
	output logic             rec_valid,
	input  logic             rec_stall,
	output logic [2:0]       component,
	output logic             present,
	output logic [POS_W-1:0] start_offset,
	output logic [POS_W-1:0] span_length,
	output logic             too_long,
	output logic             run_end
);

	batch_t     batch_q;
	logic [2:0] cnt_q;
	logic       valid_q;
	logic       last;
	rec_t       cur;

	assign last      = (cnt_q == 3'(COMP_LAST));
	// Free again once the seventh item leaves in this cycle
	assign emit_busy = valid_q & ~(last & ~rec_stall);

	// Step through the held records, one item per cycle taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (batch_load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (valid_q & ~rec_stall) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (batch_load) begin
			batch_q <= batch;
		end
	end

	assign cur          = batch_q.recs[cnt_q];
	assign rec_valid    = valid_q;
	assign component    = cnt_q;
	assign present      = cur.present;
	assign start_offset = cur.start;
	assign span_length  = cur.len;
	assign too_long     = batch_q.too_long;
	assign run_end      = last;

endmodule

// File: hdl/url_component_splitter_unit.sv
// URL component splitter.
// Input channel (byte_valid / byte_stall): one URL byte per item with
// final_byte marking the last byte of a URL. Output channel (rec_valid /
// rec_stall): seven records per URL, component 0 to 6 in order, the
// seventh carrying run_end.
// Bytes are taken at one per cycle while byte_stall is low; each passes an
// input register before the phase logic updates the record set.
// A final byte loads the record set into the output buffer once the
// previous records have drained, which makes the first record valid; the
// other six follow one per cycle while the receiver does not stall.
// Bytes of the next URL are taken while the previous records drain; only
// a further final byte waits in the input register (byte_stall high) until
// the seventh record of the previous URL is taken.
// A stalled record holds its fields unchanged.
// Reset clears the parse state and drops any pending records.
module url_component_splitter_unit import ucs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [7:0]       url_byte,
	input  logic             final_byte,
	output logic             rec_valid,
	input  logic             rec_stall,
	output logic [2:0]       component,
	output logic             present,
	output logic [POS_W-1:0] start_offset,
	output logic [POS_W-1:0] span_length,
	output logic             too_long,
	output logic             run_end
);

	logic   emit_busy;
	logic   batch_load;
	batch_t batch;

	ucs_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.url_byte   (url_byte),
		.final_byte (final_byte),
		.emit_busy  (emit_busy),
		.batch_load (batch_load),
		.batch      (batch)
	);

	ucs_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.batch_load   (batch_load),
		.batch        (batch),
		.emit_busy    (emit_busy),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.component    (component),
		.present      (present),
		.start_offset (start_offset),
		.span_length  (span_length),
		.too_long     (too_long),
		.run_end      (run_end)
	);

endmodule

// File: sim/url_split_checker.sv
module url_split_checker import ucs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic             byte_stall,
	input  logic [7:0]       url_byte,
	input  logic             final_byte,
	input  logic             rec_valid,
	input  logic             rec_stall,
	input  logic [2:0]       component,
	input  logic             present,
	input  logic [POS_W-1:0] start_offset,
	input  logic [POS_W-1:0] span_length,
	input  logic             too_long,
	input  logic             run_end,
	output int               err_count,
	output int               pending,
	output int               urls_parsed,
	output int               recs_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		ST_SKIP_SPACE,
		ST_SCHEME,
		ST_SEP1,
		ST_SEP2,
		ST_AUTH,
		ST_PORT,
		ST_PATH,
		ST_QUERY,
		ST_FRAG,
		ST_HALT
	} scan_state_t;

	typedef struct {
		comp_t            comp;
		logic             present;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] len;
		logic             too_long;
		logic             run_end;
	} comp_rec_t;

	// Records still owed by the block, oldest first
	comp_rec_t pending_recs[$];

	// Parse state of the URL in flight
	scan_state_t      scan_st;
	logic [POS_W-1:0] byte_pos;
	logic [POS_W-1:0] seg_start;
	logic             at_seen;
	logic             overflow;
	rec_t             spans[NUM_COMP];

	int errors;
	int urls;
	int recs;

	function automatic void clear_url();
		scan_st   = ST_SKIP_SPACE;
		byte_pos  = '0;
		seg_start = '0;
		at_seen   = 1'b0;
		overflow  = 1'b0;
		foreach (spans[k])
			spans[k] = '0;
	endfunction

	// Mark a component as found over [s, e), empty if e lies before s
	function automatic void mark_span(comp_t c, logic [POS_W-1:0] s, logic [POS_W-1:0] e);
		spans[c].present = 1'b1;
		spans[c].start   = s;
		spans[c].len     = (e >= s) ? POS_W'(e - s) : '0;
	endfunction

	// Advance the parse by one byte; a final byte releases seven records
	function automatic void parse_byte(logic [7:0] b, logic fin);
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] nxt;
		comp_rec_t        r;
		pos = byte_pos;
		if (pos >= POS_MAX) begin
			pos      = POS_MAX;
			overflow = 1'b1;
		end
		nxt = (pos < POS_MAX) ? POS_W'(pos + 1'b1) : POS_MAX;

		case (scan_st)
			ST_SKIP_SPACE: begin
				if (b != CH_SPACE) begin
					seg_start = pos;
					if (b == CH_SLASH) begin
						scan_st = ST_PATH;
					end else if (b == CH_COLON) begin
						mark_span(COMP_SCHEME, pos, pos);
						scan_st = ST_SEP1;
					end else begin
						scan_st = ST_SCHEME;
					end
				end
			end
			ST_SCHEME: begin
				if (b == CH_COLON) begin
					mark_span(COMP_SCHEME, seg_start, pos);
					scan_st = ST_SEP1;
				end
			end
			ST_SEP1: begin
				scan_st = (b == CH_SLASH) ? ST_SEP2 : ST_HALT;
			end
			ST_SEP2: begin
				if (b == CH_SLASH) begin
					scan_st   = ST_AUTH;
					seg_start = nxt;
					at_seen   = 1'b0;
				end else begin
					scan_st = ST_HALT;
				end
			end
			ST_AUTH: begin
				// only the first at sign closes the user part
				if (b == CH_AT && !at_seen) begin
					mark_span(COMP_USER, seg_start, pos);
					seg_start = nxt;
					at_seen   = 1'b1;
				end else if (b == CH_COLON) begin
					mark_span(COMP_HOST, seg_start, pos);
					seg_start = nxt;
					scan_st   = ST_PORT;
				end else if (b == CH_SLASH) begin
					mark_span(COMP_HOST, seg_start, pos);
					seg_start = pos;
					scan_st   = ST_PATH;
				end else if (b == CH_QUEST) begin
					mark_span(COMP_HOST, seg_start, pos);
					seg_start = nxt;
					scan_st   = ST_QUERY;
				end
			end
			ST_PORT: begin
				if (b == CH_SLASH) begin
					mark_span(COMP_PORT, seg_start, pos);
					seg_start = pos;
					scan_st   = ST_PATH;
				end else if (b == CH_QUEST) begin
					mark_span(COMP_PORT, seg_start, pos);
					seg_start = nxt;
					scan_st   = ST_QUERY;
				end
			end
			ST_PATH: begin
				if (b == CH_QUEST) begin
					mark_span(COMP_PATH, seg_start, pos);
					seg_start = nxt;
					scan_st   = ST_QUERY;
				end
			end
			ST_QUERY: begin
				if (b == CH_HASH) begin
					mark_span(COMP_QUERY, seg_start, pos);
					seg_start = nxt;
					scan_st   = ST_FRAG;
				end
			end
			default: ;
		endcase
		byte_pos = nxt;

		if (fin) begin
			// close the component still open at the end of the URL
			case (scan_st)
				ST_AUTH:  mark_span(COMP_HOST, seg_start, nxt);
				ST_PORT:  mark_span(COMP_PORT, seg_start, nxt);
				ST_PATH:  mark_span(COMP_PATH, seg_start, nxt);
				ST_QUERY: mark_span(COMP_QUERY, seg_start, nxt);
				ST_FRAG:  mark_span(COMP_FRAG, seg_start, nxt);
				default: ;
			endcase
			for (int k = 0; k < NUM_COMP; k++) begin
				r.comp     = comp_t'(k);
				r.present  = spans[k].present;
				r.start    = spans[k].present ? spans[k].start : '0;
				r.len      = spans[k].present ? spans[k].len : '0;
				r.too_long = overflow;
				r.run_end  = (comp_t'(k) == COMP_LAST);
				pending_recs.insert(pending_recs.size(), r);
			end
			clear_url();
			urls++;
		end
	endfunction

	function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Compare finished records first, then take the incoming byte
	always @(posedge clk or negedge arst_n) begin
		comp_rec_t want;
		if (!arst_n) begin
			clear_url();
			pending_recs.delete();
			errors       = 0;
			urls         = 0;
			recs         = 0;
			err_count    <= 0;
			pending      <= 0;
			urls_parsed  <= 0;
			recs_checked <= 0;
		end else begin
			if (rec_valid && !rec_stall) begin
				if (pending_recs.size() == 0) begin
					errors++;
					$display("%0t: record for component %0d with none expected", $time,
						component);
				end else begin
					want = pending_recs.pop_front();
					check_field("component", 16'(want.comp), 16'(component));
					check_field("present", 16'(want.present), 16'(present));
					check_field("start_offset", 16'(want.start), 16'(start_offset));
					check_field("span_length", 16'(want.len), 16'(span_length));
					check_field("too_long", 16'(want.too_long), 16'(too_long));
					check_field("run_end", 16'(want.run_end), 16'(run_end));
					recs++;
				end
			end
			if (byte_valid && !byte_stall)
				parse_byte(url_byte, final_byte);
			err_count    <= errors;
			pending      <= pending_recs.size();
			urls_parsed  <= urls;
			recs_checked <= recs;
		end
	end

endmodule

// File: sim/tb_url_component_splitter_unit.sv
module tb_url_component_splitter_unit;
	import ucs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 320;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 12;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             byte_valid;
	logic             byte_stall;
	logic [7:0]       url_byte;
	logic             final_byte;
	logic             rec_valid;
	logic             rec_stall = 1'b0;
	logic [2:0]       component;
	logic             present;
	logic [POS_W-1:0] start_offset;
	logic [POS_W-1:0] span_length;
	logic             too_long;
	logic             run_end;

	int err_count;
	int pending;
	int urls_parsed;
	int recs_checked;

	logic [7:0] url_text[$];
	int         burst_left;
	int         bytes_sent;
	int         idle_cycles;
	int         stall_tick;

	url_component_splitter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.url_byte     (url_byte),
		.final_byte   (final_byte),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.component    (component),
		.present      (present),
		.start_offset (start_offset),
		.span_length  (span_length),
		.too_long     (too_long),
		.run_end      (run_end)
	);

	url_split_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.url_byte     (url_byte),
		.final_byte   (final_byte),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.component    (component),
		.present      (present),
		.start_offset (start_offset),
		.span_length  (span_length),
		.too_long     (too_long),
		.run_end      (run_end),
		.err_count    (err_count),
		.pending      (pending),
		.urls_parsed  (urls_parsed),
		.recs_checked (recs_checked)
	);

	always #5ns clk = ~clk;

	// Stall the record channel: free flow, random, then a fixed beat
	always @(negedge clk) begin
		stall_tick++;
		case ((stall_tick / 256) % 3)
			0:       rec_stall <= 1'b0;
			1:       rec_stall <= ($urandom_range(0, 2) == 0);
			default: rec_stall <= ((stall_tick % 13) < 5);
		endcase
	end

	// End the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (rec_valid && !rec_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Add one byte to the end of the URL being built
	function automatic void append_byte(logic [7:0] b);
		url_text.insert(url_text.size(), b);
	endfunction

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 5))
			0:       return CH_COLON;
			1:       return CH_SLASH;
			2:       return CH_QUEST;
			3:       return CH_HASH;
			4:       return CH_AT;
			default: return CH_SPACE;
		endcase
	endfunction

	// Component text: mostly letters, now and then a separator or any byte
	function automatic void add_text(int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 19)) inside
				0, 1:    append_byte(pick_separator());
				2:       append_byte(8'($urandom));
				default: append_byte(8'($urandom_range(8'h61, 8'h7A)));
			endcase
		end
	endfunction

	function automatic void add_str(string s);
		foreach (s[i])
			append_byte(8'(s[i]));
	endfunction

	// Hand over one byte, opening a new burst after a random gap
	task automatic send_byte(logic [7:0] b, logic fin);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = $urandom_range(1, 16);
			repeat (gap) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				url_byte   <= 8'($urandom);
				final_byte <= 1'($urandom);
			end
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		url_byte   <= b;
		final_byte <= fin;
		do
			@(posedge clk);
		while (byte_stall !== 1'b0);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_url();
		foreach (url_text[i])
			send_byte(url_text[i], i == url_text.size() - 1);
		url_text.delete();
	endtask

	// Build a URL: mostly well formed, some cut short, some plain noise
	task automatic build_random_url();
		int unsigned kind;
		int unsigned cut;
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) append_byte(CH_SPACE);
		if (kind >= 8) begin
			repeat ($urandom_range(1, 12))
				append_byte($urandom_range(0, 1) ? pick_separator() : 8'($urandom));
			return;
		end
		if ($urandom_range(0, 4) == 0) begin
			append_byte(CH_SLASH);
			add_text($urandom_range(0, 5));
		end else begin
			add_text($urandom_range(0, 4));
			append_byte(CH_COLON);
			append_byte(CH_SLASH);
			append_byte(CH_SLASH);
			if ($urandom_range(0, 1)) begin
				add_text($urandom_range(0, 3));
				append_byte(CH_AT);
			end
			add_text($urandom_range(0, 5));
			if ($urandom_range(0, 1)) begin
				append_byte(CH_COLON);
				add_text($urandom_range(0, 4));
			end
			if ($urandom_range(0, 1)) begin
				append_byte(CH_SLASH);
				add_text($urandom_range(0, 5));
			end
		end
		if ($urandom_range(0, 1)) begin
			append_byte(CH_QUEST);
			add_text($urandom_range(0, 4));
		end
		if ($urandom_range(0, 1)) begin
			append_byte(CH_HASH);
			add_text($urandom_range(0, 4));
		end
		// cut a well formed URL at a random point
		if (kind == 7) begin
			cut      = $urandom_range(1, url_text.size());
			url_text = url_text[0:cut-1];
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		url_byte   = '0;
		final_byte = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: spaces only, extreme bytes in an unfinished scheme,
		// bad and cut separators, a second at sign with every component and
		// separators as last byte, a lone slash
		add_str(" ");
		send_url();
		url_text = '{8'hFF, 8'h00};
		send_url();
		add_str(":/x");
		send_url();
		add_str("a:/");
		send_url();
		add_str("s://u@@:/?#");
		send_url();
		add_str("/");
		send_url();

		// Random URLs with random content
		while (bytes_sent < RANDOM_BYTES) begin
			build_random_url();
			send_url();
		end

		@(negedge clk);
		byte_valid <= 1'b0;

		// Drain outstanding records, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Split %0d directed and random URLs from %0d bytes, bursty input,",
			urls_parsed, bytes_sent);
		$display("stalled records; compared %0d component records, %0d mismatches.",
			recs_checked, err_count);
		if (err_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/ucs_pkg.sv
hdl/ucs_parser.sv
hdl/ucs_emitter.sv
hdl/url_component_splitter_unit.sv
sim/url_split_checker.sv
sim/tb_url_component_splitter_unit.sv
